// ===== hw/rtl/srk4_pkg.sv =====
// Shared types, constants and fixed-point helpers of the SIR Runge-Kutta step unit.
`default_nettype none

package srk4_pkg;

    localparam int DataW      = 32;
    localparam int FracW      = 28;
    localparam int AccW       = 36;   // weighted stage sum k1 + 2k2 + 2k3 + k4
    localparam int MagW       = 35;   // magnitude of that sum
    localparam int WideW      = 37;
    localparam int PieceW     = 18;   // operand slice of the reciprocal multiplier
    localparam int RecipW     = 35;
    localparam int RecipShift = 37;
    localparam int ProdW      = MagW + RecipW;
    localparam int DivSteps   = 4;
    localparam int DivCntW    = 2;
    localparam int UopW       = 3;
    localparam int StageW     = 2;

    localparam logic [UopW-1:0]    UopLast   = 3'd5;
    localparam logic [StageW-1:0]  StageLast = 2'd3;
    localparam logic [DivCntW-1:0] DivLast   = DivCntW'(DivSteps - 1);
    // Smallest integer not below 2^37 / 6; exact for magnitudes under 2^35.
    localparam logic [RecipW-1:0]  RecipSix  = 35'h5_5555_5556;

    localparam logic [DataW-1:0] BetaReset  = 32'd93952410;
    localparam logic [DataW-1:0] GammaReset = 32'd21474836;
    localparam logic [DataW-1:0] DtReset    = 32'd26843546;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] RegInfection = 2'd0;
    localparam logic [CfgIdxW-1:0] RegRecovery  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegTimeStep  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIVI,
        S_DIV,
        S_WB,
        S_PUB
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_BS,
        OP_BSI,
        OP_GI,
        OP_KS,
        OP_KI,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WB,
        OP_PUB
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [StageW-1:0] stage;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Saturate a 37-bit signed value to the signed 32-bit range.
    function automatic logic signed [DataW-1:0] sat37(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] hi;
        logic signed [WideW-1:0] lo;
        hi = WideW'(signed'(32'sh7FFF_FFFF));
        lo = WideW'(signed'(32'sh8000_0000));
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DataW-1:0];
    endfunction

    // Q4.28 product, floored, saturated.
    function automatic logic signed [DataW-1:0] qmul(input logic signed [DataW:0] a,
                                                     input logic signed [DataW-1:0] b);
        logic signed [2*DataW:0] p;
        p = a * b;
        return sat37(p[2*DataW:FracW]);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srk4_ctrl.sv =====
// Sequencing state machine of the SIR Runge-Kutta step unit.
`default_nettype none

module srk4_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             action,
    output logic                  in_ready,
    input  srk4_pkg::status_t     status,
    output srk4_pkg::cmd_t        cmd
);
    import srk4_pkg::*;

    state_t              state_reg, state_next;
    logic [UopW-1:0]     uop_reg, uop_next;
    logic [StageW-1:0]   stage_reg, stage_next;
    logic [DivCntW-1:0]  div_reg, div_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            uop_reg   <= '0;
            stage_reg <= '0;
            div_reg   <= '0;
        end else begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
            stage_reg <= stage_next;
            div_reg   <= div_next;
        end
    end

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        uop_next   = uop_reg;
        stage_next = stage_reg;
        div_next   = div_reg;
        unique case (state_reg)
            S_IDLE: begin
                uop_next   = '0;
                stage_next = '0;
                if (in_valid) begin
                    state_next = action ? S_CALC : S_PUB;
                end
            end
            S_CALC: begin
                if (uop_reg == UopLast) begin
                    uop_next   = '0;
                    stage_next = stage_reg + 2'd1;
                    if (stage_reg == StageLast) begin
                        state_next = S_DIVI;
                    end
                end else begin
                    uop_next = uop_reg + 3'd1;
                end
            end
            S_DIVI: begin
                div_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                div_next = div_reg + DivCntW'(1);
                if (div_reg == DivLast) begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                state_next = S_PUB;
            end
            S_PUB: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        in_ready  = 1'b0;
        cmd.op    = OP_NONE;
        cmd.stage = stage_reg;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op = action ? OP_INIT : OP_LOAD;
                end
            end
            S_CALC: begin
                unique case (uop_reg)
                    3'd0:    cmd.op = OP_BS;
                    3'd1:    cmd.op = OP_BSI;
                    3'd2:    cmd.op = OP_GI;
                    3'd3:    cmd.op = OP_KS;
                    3'd4:    cmd.op = OP_KI;
                    default: cmd.op = OP_ACC;
                endcase
            end
            S_DIVI:  cmd.op = OP_DIV_INIT;
            S_DIV: begin
                cmd.op    = OP_DIV_STEP;
                cmd.stage = div_reg;
            end
            S_WB:    cmd.op = OP_WB;
            S_PUB:   cmd.op = status.out_free ? OP_PUB : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !action) |=> (state_reg == S_PUB))
        else $error("load transaction did not go straight to publish");
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_reg != DivLast) |=> (state_reg == S_DIV))
        else $error("division left early");
    a_calc_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && !(uop_reg == UopLast && stage_reg == StageLast))
        |=> (state_reg == S_CALC))
        else $error("stage sequence left early");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/srk4_datapath.sv =====
// Registers, shared multiplier and divide-by-six unit of the SIR Runge-Kutta step unit.
`default_nettype none

module srk4_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  srk4_pkg::cmd_t                        cmd,
    output srk4_pkg::status_t                     status,
    input  wire logic                             cfg_we,
    input  wire logic [srk4_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [srk4_pkg::DataW-1:0]       cfg_data,
    input  wire logic [28:0]                      initial_susceptible,
    input  wire logic [28:0]                      initial_infected,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [srk4_pkg::DataW-1:0]     susceptible,
    output logic signed [srk4_pkg::DataW-1:0]     infected,
    output logic [srk4_pkg::DataW-1:0]            steps_taken
);
    import srk4_pkg::*;

    logic [DataW-1:0] beta_reg, gamma_reg, dt_reg;
    logic signed [DataW-1:0] s_reg, i_reg;
    logic [DataW-1:0] cnt_reg;
    logic signed [DataW-1:0] sa_reg, ia_reg, bs_reg, bsi_reg, gi_reg, ks_reg, ki_reg;
    logic signed [AccW-1:0] ws_reg, wi_reg;
    logic [MagW-1:0] dqs_reg, dqi_reg;
    logic [ProdW-1:0] accs_reg, acci_reg;
    logic negs_reg, negi_reg;
    logic out_valid_reg;
    logic signed [DataW-1:0] sus_reg, inf_reg;
    logic [DataW-1:0] steps_reg;

    logic signed [DataW:0]   mul_a;
    logic signed [DataW-1:0] mul_b;
    logic signed [DataW-1:0] mul_q;
    logic signed [DataW-1:0] rate_s, rate_i;
    logic signed [DataW:0]   half_s, half_i;
    logic signed [DataW-1:0] arg_s, arg_i;
    logic full_k, double_k;
    logic [PieceW-1:0] piece_s, piece_i, piece_r;
    logic [2*PieceW-1:0] pp_s, pp_i;
    logic [ProdW-1:0] term_s, term_i;
    logic [ProdW-RecipShift-1:0] quo_s, quo_i;
    logic signed [AccW-1:0] q_s, q_i;

    assign status.out_free = !out_valid_reg || out_ready;

    // Stage derivatives, taken from the registered products.
    assign rate_s = sat37(-WideW'(bsi_reg));
    assign rate_i = sat37(WideW'(bsi_reg) - WideW'(gi_reg));

    // One shared multiplier, operands chosen by the current command.
    always_comb begin
        mul_a = (DataW+1)'(signed'({1'b0, beta_reg}));
        mul_b = sa_reg;
        unique case (cmd.op)
            OP_BS:  begin mul_a = signed'({1'b0, beta_reg});  mul_b = sa_reg; end
            OP_BSI: begin mul_a = (DataW+1)'(bs_reg);          mul_b = ia_reg; end
            OP_GI:  begin mul_a = signed'({1'b0, gamma_reg}); mul_b = ia_reg; end
            OP_KS:  begin mul_a = signed'({1'b0, dt_reg});    mul_b = rate_s; end
            OP_KI:  begin mul_a = signed'({1'b0, dt_reg});    mul_b = rate_i; end
            default: begin end
        endcase
    end
    assign mul_q = qmul(mul_a, mul_b);

    // Next stage arguments: half of k toward zero, or all of k for the last stage.
    assign full_k   = (cmd.stage == 2'd2);
    assign double_k = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);
    assign half_s = ((DataW+1)'(ks_reg) + signed'((DataW+1)'(ks_reg[DataW-1]))) >>> 1;
    assign half_i = ((DataW+1)'(ki_reg) + signed'((DataW+1)'(ki_reg[DataW-1]))) >>> 1;
    assign arg_s = sat37(WideW'(s_reg) + (full_k ? WideW'(ks_reg) : WideW'(half_s)));
    assign arg_i = sat37(WideW'(i_reg) + (full_k ? WideW'(ki_reg) : WideW'(half_i)));

    // Divide by six as a multiplication by the reciprocal, one partial product of
    // slices per cycle: bit 1 of the step picks the magnitude slice, bit 0 the
    // reciprocal slice.
    assign piece_s = cmd.stage[1] ? PieceW'(dqs_reg[MagW-1:PieceW]) : dqs_reg[PieceW-1:0];
    assign piece_i = cmd.stage[1] ? PieceW'(dqi_reg[MagW-1:PieceW]) : dqi_reg[PieceW-1:0];
    assign piece_r = cmd.stage[0] ? PieceW'(RecipSix[RecipW-1:PieceW])
                                  : RecipSix[PieceW-1:0];
    assign pp_s = piece_s * piece_r;
    assign pp_i = piece_i * piece_r;

    always_comb begin
        unique case (cmd.stage)
            2'd0: begin
                term_s = ProdW'(pp_s);
                term_i = ProdW'(pp_i);
            end
            2'd3: begin
                term_s = ProdW'(pp_s) << (2 * PieceW);
                term_i = ProdW'(pp_i) << (2 * PieceW);
            end
            default: begin
                term_s = ProdW'(pp_s) << PieceW;
                term_i = ProdW'(pp_i) << PieceW;
            end
        endcase
    end

    assign quo_s = accs_reg[ProdW-1:RecipShift];
    assign quo_i = acci_reg[ProdW-1:RecipShift];
    assign q_s = negs_reg ? -AccW'(signed'({1'b0, quo_s})) : AccW'(signed'({1'b0, quo_s}));
    assign q_i = negi_reg ? -AccW'(signed'({1'b0, quo_i})) : AccW'(signed'({1'b0, quo_i}));

    // Control state, configuration and model state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            beta_reg      <= BetaReset;
            gamma_reg     <= GammaReset;
            dt_reg        <= DtReset;
            s_reg         <= '0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == RegInfection) beta_reg  <= cfg_data;
                if (cfg_index == RegRecovery)  gamma_reg <= cfg_data;
                if (cfg_index == RegTimeStep)  dt_reg    <= cfg_data;
            end
            if (cmd.op == OP_LOAD) begin
                s_reg   <= signed'(DataW'(initial_susceptible));
                i_reg   <= signed'(DataW'(initial_infected));
                cnt_reg <= '0;
            end else if (cmd.op == OP_WB) begin
                s_reg   <= sat37(WideW'(s_reg) + WideW'(q_s));
                i_reg   <= sat37(WideW'(i_reg) + WideW'(q_i));
                cnt_reg <= cnt_reg + 32'd1;
            end
            if (cmd.op == OP_PUB) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the step.
    always_ff @(posedge clk) begin
        unique case (cmd.op)
            OP_INIT: begin
                sa_reg <= s_reg;
                ia_reg <= i_reg;
                ws_reg <= '0;
                wi_reg <= '0;
            end
            OP_BS:  bs_reg  <= mul_q;
            OP_BSI: bsi_reg <= mul_q;
            OP_GI:  gi_reg  <= mul_q;
            OP_KS:  ks_reg  <= mul_q;
            OP_KI:  ki_reg  <= mul_q;
            OP_ACC: begin
                ws_reg <= ws_reg + (double_k ? (AccW'(ks_reg) <<< 1) : AccW'(ks_reg));
                wi_reg <= wi_reg + (double_k ? (AccW'(ki_reg) <<< 1) : AccW'(ki_reg));
                sa_reg <= arg_s;
                ia_reg <= arg_i;
            end
            OP_DIV_INIT: begin
                negs_reg <= ws_reg[AccW-1];
                negi_reg <= wi_reg[AccW-1];
                dqs_reg  <= ws_reg[AccW-1] ? MagW'(-ws_reg) : MagW'(ws_reg);
                dqi_reg  <= wi_reg[AccW-1] ? MagW'(-wi_reg) : MagW'(wi_reg);
                accs_reg <= '0;
                acci_reg <= '0;
            end
            OP_DIV_STEP: begin
                accs_reg <= accs_reg + term_s;
                acci_reg <= acci_reg + term_i;
            end
            OP_PUB: begin
                sus_reg   <= s_reg;
                inf_reg   <= i_reg;
                steps_reg <= cnt_reg;
            end
            default: begin end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign susceptible = sus_reg;
    assign infected    = inf_reg;
    assign steps_taken = steps_reg;

`ifndef ASSERT_OFF
    a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUB) |-> (!out_valid_reg || out_ready))
        else $error("result published over a pending transaction");
    a_wb_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WB) |=> (cnt_reg == $past(cnt_reg) + 32'd1))
        else $error("step counter not advanced on write-back");
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.op) == OP_DIV_INIT) |-> (!dqs_reg[MagW-1] && !dqi_reg[MagW-1]))
        else $error("weighted sum magnitude out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sir_rk4_step_unit.sv =====
// Top level of the SIR epidemic Runge-Kutta step unit.
// A load transaction goes straight to publish; a step transaction runs the multiplier
// micro-operations of the four stages, one divider set-up, four reciprocal partial
// products for the divide by six, write-back and publish.
// Throughput: one transaction at a time; the next is accepted in the cycle after publish.
// Reset (rst_n, asynchronous, active low) zeroes s, i and steps and restores the rates.
`default_nettype none

module sir_rk4_step_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             action,
    input  wire logic [28:0]                      initial_susceptible,
    input  wire logic [28:0]                      initial_infected,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [srk4_pkg::DataW-1:0]     susceptible,
    output logic signed [srk4_pkg::DataW-1:0]     infected,
    output logic [srk4_pkg::DataW-1:0]            steps_taken,
    input  wire logic                             cfg_we,
    input  wire logic [srk4_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [srk4_pkg::DataW-1:0]       cfg_data
);
    import srk4_pkg::*;

    // The controller walks the stage micro-operations and the divider; the datapath
    // holds the state, the shared stage multiplier and the output register, so a
    // finished transaction can wait at the output while the next one is accepted.
    cmd_t    cmd;
    status_t status;

    srk4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srk4_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .initial_susceptible (initial_susceptible),
        .initial_infected    (initial_infected),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .susceptible         (susceptible),
        .infected            (infected),
        .steps_taken         (steps_taken)
    );

endmodule

`default_nettype wire
